/* rtl/core/shabc_pkg.sv */
// Shared types, constants and functions of the SHA-256 block compression core.
`default_nettype none

package shabc_pkg;

  localparam int unsigned NumHashWords  = 8;
  localparam int unsigned NumSchedWords = 16;
  localparam int unsigned NumRounds     = 64;

  typedef logic [31:0] word_t;
  typedef logic [2:0]  hash_idx_t;
  typedef logic [3:0]  word_cnt_t;
  typedef logic [5:0]  round_idx_t;

  // Input word: one message word plus the first-block flag
  typedef struct packed {
    logic [31:0] message_word;
    logic        first_block;
  } in_word_t;

  // Result word: one chaining hash word with its position and a last flag
  typedef struct packed {
    logic [31:0] hash_word;
    logic [2:0]  word_index;
    logic        last;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       take_word;
    logic       reload_iv;
    logic       load_vars;
    logic       do_round;
    round_idx_t round_idx;
    logic       add_hash;
    logic       emit;
    hash_idx_t  emit_idx;
  } cmd_t;

  function automatic word_t ror32(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big0(word_t x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t big1(word_t x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic word_t small0(word_t x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small1(word_t x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  // Initial hash values; sel_256 picks SHA-256 over SHA-224
  function automatic word_t init_hash(logic sel_256, hash_idx_t idx);
    word_t v;
    if (sel_256) begin
      case (idx)
        3'd0:    v = 32'h6a09e667;
        3'd1:    v = 32'hbb67ae85;
        3'd2:    v = 32'h3c6ef372;
        3'd3:    v = 32'ha54ff53a;
        3'd4:    v = 32'h510e527f;
        3'd5:    v = 32'h9b05688c;
        3'd6:    v = 32'h1f83d9ab;
        default: v = 32'h5be0cd19;
      endcase
    end else begin
      case (idx)
        3'd0:    v = 32'hc1059ed8;
        3'd1:    v = 32'h367cd507;
        3'd2:    v = 32'h3070dd17;
        3'd3:    v = 32'hf70e5939;
        3'd4:    v = 32'hffc00b31;
        3'd5:    v = 32'h68581511;
        3'd6:    v = 32'h64f98fa7;
        default: v = 32'hbefa4fa4;
      endcase
    end
    return v;
  endfunction

  // Round constants
  function automatic word_t round_k(round_idx_t idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/shabc_ctrl.sv */
// Controller state machine: word counting, round sequencing and result emission.
`default_nettype none

module shabc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            first_block_i,
  output logic                 busy_o,
  output shabc_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  localparam shabc_pkg::word_cnt_t  LastWord  =
    shabc_pkg::word_cnt_t'(shabc_pkg::NumSchedWords - 1);
  localparam shabc_pkg::round_idx_t LastRound =
    shabc_pkg::round_idx_t'(shabc_pkg::NumRounds - 1);
  localparam shabc_pkg::hash_idx_t  LastEmit  =
    shabc_pkg::hash_idx_t'(shabc_pkg::NumHashWords - 1);

  state_e                 state_q, state_d;
  shabc_pkg::word_cnt_t   word_cnt_q, word_cnt_d;
  shabc_pkg::round_idx_t  round_q, round_d;
  shabc_pkg::hash_idx_t   emit_q, emit_d;
  logic                   accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i & ~busy_o;

  // Advance the sequence
  always_comb begin
    state_d    = state_q;
    word_cnt_d = word_cnt_q;
    round_d    = round_q;
    emit_d     = emit_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          word_cnt_d = word_cnt_q + 4'd1;
          if (word_cnt_q == LastWord) begin
            round_d = '0;
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        round_d = round_q + 6'd1;
        if (round_q == LastRound) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        emit_d  = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        emit_d = emit_q + 3'd1;
        if (emit_q == LastEmit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      word_cnt_q <= '0;
      round_q    <= '0;
      emit_q     <= '0;
    end else begin
      state_q    <= state_d;
      word_cnt_q <= word_cnt_d;
      round_q    <= round_d;
      emit_q     <= emit_d;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd_o.take_word = accept;
    cmd_o.reload_iv = accept & first_block_i;
    cmd_o.load_vars = accept & (word_cnt_q == LastWord);
    cmd_o.do_round  = (state_q == ST_ROUND);
    cmd_o.round_idx = round_q;
    cmd_o.add_hash  = (state_q == ST_ADD);
    cmd_o.emit      = (state_q == ST_EMIT);
    cmd_o.emit_idx  = emit_q;
  end

endmodule

`default_nettype wire

/* rtl/core/shabc_dp.sv */
// Datapath: message schedule window, round unit, chaining hash and result register.
`default_nettype none

module shabc_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i,
  input  wire logic [31:0]          message_word_i,
  input  wire shabc_pkg::cmd_t      cmd_i,
  output shabc_pkg::out_word_t      result_o,
  output logic                      result_valid_o
);

  localparam int unsigned NH = shabc_pkg::NumHashWords;
  localparam int unsigned NS = shabc_pkg::NumSchedWords;
  localparam shabc_pkg::hash_idx_t LastIdx = shabc_pkg::hash_idx_t'(NH - 1);

  logic                 variant_q;
  shabc_pkg::word_t     hash_q  [NH];
  shabc_pkg::word_t     wv_q    [NH];
  shabc_pkg::word_t     sched_q [NS];
  shabc_pkg::out_word_t res_q;
  logic                 res_valid_q;

  shabc_pkg::word_t     sched_new;
  shabc_pkg::word_t     ch, maj, t1, t2;

  // Hold the variant select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 1'b1;
    end else if (cmd_i.take_word == 1'b0 && cfg_we_i) begin
      variant_q <= cfg_wdata_i;
    end else if (cfg_we_i) begin
      variant_q <= cfg_wdata_i;
    end
  end

  // Expand the next schedule word from the window
  assign sched_new = shabc_pkg::small1(sched_q[14]) + sched_q[9]
                   + shabc_pkg::small0(sched_q[1]) + sched_q[0];

  // Shift words in at the top; the oldest sits at entry 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_word) begin
      for (int i = 0; i < NS - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[NS-1] <= message_word_i;
    end else if (cmd_i.do_round) begin
      for (int i = 0; i < NS - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[NS-1] <= sched_new;
    end
  end

  // One compression round
  assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
  assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
  assign t1  = wv_q[7] + shabc_pkg::big1(wv_q[4]) + ch
             + shabc_pkg::round_k(cmd_i.round_idx) + sched_q[0];
  assign t2  = shabc_pkg::big0(wv_q[0]) + maj;

  // Load, then rotate the working variables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NH; i++) begin
        wv_q[i] <= '0;
      end
    end else if (cmd_i.load_vars) begin
      for (int i = 0; i < NH; i++) begin
        wv_q[i] <= cmd_i.reload_iv ?
                   shabc_pkg::init_hash(variant_q, shabc_pkg::hash_idx_t'(i)) : hash_q[i];
      end
    end else if (cmd_i.do_round) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
  end

  // Reload or accumulate the chaining hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NH; i++) begin
        hash_q[i] <= shabc_pkg::init_hash(1'b1, shabc_pkg::hash_idx_t'(i));
      end
    end else if (cmd_i.reload_iv) begin
      for (int i = 0; i < NH; i++) begin
        hash_q[i] <= shabc_pkg::init_hash(variant_q, shabc_pkg::hash_idx_t'(i));
      end
    end else if (cmd_i.add_hash) begin
      for (int i = 0; i < NH; i++) begin
        hash_q[i] <= hash_q[i] + wv_q[i];
      end
    end
  end

  // Register each result word as it is emitted
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.hash_word  <= hash_q[cmd_i.emit_idx];
      res_q.word_index <= cmd_i.emit_idx;
      res_q.last       <= (cmd_i.emit_idx == LastIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule

`default_nettype wire

/* rtl/core/sha256_block_compress.sv */
// Top level of the SHA-256 block compression core.
`default_nettype none

// SHA-256/SHA-224 block compression. Message words are taken one per cycle
// while busy_o is low (start_i high). The sixteenth word of a block starts the
// compression: busy_o then stays high through 64 rounds in a single round
// unit at one per cycle, the add into the chaining hash, and the emission of
// the eight updated hash words, which come out registered one per cycle on
// result_valid_o, word 0 first and word 7 marked last. The result strobe
// lasts one cycle and cannot be stalled; the receiver must take every word
// as it comes. first_block reloads the initial values chosen by the variant
// bit (SHA-256 after reset); a variant write takes effect at the next
// first_block.
module sha256_block_compress (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire shabc_pkg::in_word_t   word_i,
  output logic                       busy_o,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_wdata_i,
  output shabc_pkg::out_word_t       result_o,
  output logic                       result_valid_o
);

  shabc_pkg::cmd_t cmd;

  shabc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .first_block_i (word_i.first_block),
    .busy_o        (busy_o),
    .cmd_o         (cmd)
  );

  shabc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .message_word_i (word_i.message_word),
    .cmd_i          (cmd),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

`ifndef ASSERT_OFF
  // Results only come out while the core holds off new words, but the last
  // one, being registered, comes out once busy_o has already fallen
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy_o)
    else $error("result word outside compression");

  // A burst starts at word 0
  a_res_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> (result_o.word_index == 3'd0))
    else $error("result burst does not start at word 0");

  // Words within a burst follow in order without gaps
  a_res_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |=>
      (result_valid_o && result_o.word_index == $past(result_o.word_index) + 3'd1))
    else $error("result burst out of order");

  // The last word ends the burst
  a_res_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !result_valid_o)
    else $error("result burst runs past last word");
`endif

endmodule

`default_nettype wire

/* tb/tb_sha256_block_compress.sv */
// Self-checking testbench for the SHA-256/SHA-224 block compression core.
module tb_sha256_block_compress;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned MAX_REPORTS  = 10;

  // Round constants, word 0 in the top 32 bits
  localparam logic [64*32-1:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial chaining values, word 0 in the top 32 bits
  localparam logic [8*32-1:0] IV_256 = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [8*32-1:0] IV_224 = {
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  shabc_pkg::in_word_t   word_i      = '0;
  logic                  cfg_we_i    = 1'b0;
  logic                  cfg_wdata_i = 1'b1;
  logic                  busy_o;
  shabc_pkg::out_word_t  result_o;
  logic                  result_valid_o;

  // Predictor state
  logic                  sel_sha256;
  shabc_pkg::word_t      chain_hash [8];
  shabc_pkg::word_t      sched_win  [16];
  logic [3:0]            word_pos;

  shabc_pkg::in_word_t   msg_words_q [$];
  shabc_pkg::out_word_t  hash_words_due [$];
  logic                  word_taken   = 1'b0;
  logic                  no_gaps      = 1'b0;
  int                    mismatch_cnt = 0;
  int                    quiet_cycles = 0;

  sha256_block_compress u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .word_i         (word_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // Generate the clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic shabc_pkg::word_t rot_right(shabc_pkg::word_t x, int unsigned n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic shabc_pkg::word_t csig0(shabc_pkg::word_t x);
    return rot_right(x, 2) ^ rot_right(x, 13) ^ rot_right(x, 22);
  endfunction

  function automatic shabc_pkg::word_t csig1(shabc_pkg::word_t x);
    return rot_right(x, 6) ^ rot_right(x, 11) ^ rot_right(x, 25);
  endfunction

  function automatic shabc_pkg::word_t ssig0(shabc_pkg::word_t x);
    return rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3);
  endfunction

  function automatic shabc_pkg::word_t ssig1(shabc_pkg::word_t x);
    return rot_right(x, 17) ^ rot_right(x, 19) ^ (x >> 10);
  endfunction

  task automatic load_iv();
    int i;
    for (i = 0; i < 8; i++) begin
      chain_hash[i] = sel_sha256 ? IV_256[(7 - i)*32 +: 32] : IV_224[(7 - i)*32 +: 32];
    end
  endtask

  // Run 64 rounds over the schedule window and queue the eight updated hash words
  task automatic compress_block();
    shabc_pkg::word_t     v [8];
    shabc_pkg::word_t     t1;
    shabc_pkg::word_t     t2;
    shabc_pkg::out_word_t hw;
    int                   i;
    int                   r;
    for (i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (r = 0; r < 64; r++) begin
      if (r >= 16) begin
        sched_win[r & 15] = ssig1(sched_win[(r + 14) & 15]) + sched_win[(r + 9) & 15]
                          + ssig0(sched_win[(r + 1) & 15]) + sched_win[r & 15];
      end
      t1 = v[7] + csig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + ROUND_K[(63 - r)*32 +: 32] + sched_win[r & 15];
      t2 = csig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) begin
      chain_hash[i] = chain_hash[i] + v[i];
      hw.hash_word  = chain_hash[i];
      hw.word_index = 3'(i);
      hw.last       = (i == 7);
      hash_words_due.push_back(hw);
    end
  endtask

  // Take one accepted message word; a full block yields eight hash words
  task automatic absorb_word(shabc_pkg::in_word_t w);
    if (w.first_block) load_iv();
    sched_win[word_pos] = w.message_word;
    word_pos = word_pos + 4'd1;
    if (word_pos == 4'd0) compress_block();
  endtask

  task automatic flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Queue one run of words with random content; reload_at < 0 means no reload
  task automatic queue_block(int n_words, int reload_at);
    shabc_pkg::in_word_t w;
    int                  i;
    for (i = 0; i < n_words; i++) begin
      w.message_word = $urandom;
      w.first_block  = (i == reload_at);
      msg_words_q.push_back(w);
    end
  endtask

  // Queue whole blocks, mostly starting a new message, some chained, a few odd reloads
  task automatic queue_random_blocks(int n_blocks);
    int b;
    int pick;
    for (b = 0; b < n_blocks; b++) begin
      pick = $urandom_range(99);
      if (pick < 60) queue_block(16, 0);
      else if (pick < 85) queue_block(16, -1);
      else queue_block(16, $urandom_range(15, 1));
    end
  endtask

  // Wait for all words to go in and all hash words to come out, then let the core settle
  task automatic drain();
    while (msg_words_q.size() != 0 || start_i) @(posedge clk_i);
    while (hash_words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the variant bit while the core is idle
  task automatic set_variant(logic sel);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sel;
    @(posedge clk_i);
    sel_sha256 = sel;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drive the next word, hold it until taken, idle now and then
  always @(negedge clk_i) begin : drive_words
    if (!start_i || word_taken) begin
      if (msg_words_q.size() != 0 && (no_gaps || $urandom_range(99) >= 6)) begin
        start_i <= 1'b1;
        word_i  <= msg_words_q.pop_front();
      end else begin
        start_i <= 1'b0;
        word_i  <= shabc_pkg::in_word_t'({$urandom, 1'($urandom_range(1))});
      end
    end
  end

  // Sample accepted words and check each hash word against the oldest prediction
  always @(posedge clk_i) begin : watch_ports
    shabc_pkg::out_word_t due;
    word_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) absorb_word(word_i);
    if (rst_ni && result_valid_o) begin
      if (hash_words_due.size() == 0) begin
        flag_error($sformatf("hash word with nothing due: word %h idx %0d last %b",
                             result_o.hash_word, result_o.word_index, result_o.last));
      end else begin
        due = hash_words_due.pop_front();
        if (result_o.hash_word !== due.hash_word || result_o.word_index !== due.word_index ||
            result_o.last !== due.last) begin
          flag_error($sformatf("exp word %h idx %0d last %b, got word %h idx %0d last %b",
                               due.hash_word, due.word_index, due.last,
                               result_o.hash_word, result_o.word_index, result_o.last));
        end
      end
    end
  end

  // Abort if nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if (rst_ni && ((start_i && !busy_o) || result_valid_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : run_regression
    shabc_pkg::in_word_t w;
    int                  i;
    // Predictor comes out of reset with SHA-256 values selected
    sel_sha256 = 1'b1;
    load_iv();
    for (i = 0; i < 16; i++) sched_win[i] = '0;
    word_pos = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed block: extreme words, chaining from the reset values, reload mid-block
    for (i = 0; i < 16; i++) begin
      case (i)
        0:       w.message_word = 32'h0000_0000;
        1:       w.message_word = 32'hffff_ffff;
        2:       w.message_word = 32'h8000_0000;
        3:       w.message_word = 32'h0000_0001;
        4:       w.message_word = 32'haaaa_aaaa;
        5:       w.message_word = 32'h5555_5555;
        default: w.message_word = $urandom;
      endcase
      w.first_block = (i == 9);
      msg_words_q.push_back(w);
    end
    drain();

    // Variant change leaves the hash alone until the next reload
    set_variant(1'b0);
    queue_block(16, -1);
    queue_block(16, 0);
    drain();

    // Back-to-back words with no gaps
    set_variant(1'b1);
    no_gaps = 1'b1;
    queue_random_blocks(2);
    drain();
    no_gaps = 1'b0;

    // End on a partial block so word position carries across the write
    set_variant(1'b0);
    queue_random_blocks(1);
    queue_block($urandom_range(15, 1), -1);
    drain();

    set_variant(1'b1);
    queue_random_blocks(1);
    drain();

    if (mismatch_cnt == 0 && hash_words_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sha256_block_compress.f */
rtl/core/shabc_pkg.sv
rtl/core/shabc_ctrl.sv
rtl/core/shabc_dp.sv
rtl/core/sha256_block_compress.sv
tb/tb_sha256_block_compress.sv
